@@ sv/mtrd_pkg.sv @@
// Shared constants and helpers for the ranged MT19937 draw block.
package mtrd_pkg;
  localparam int unsigned StateWords   = 624;
  localparam int unsigned MiddleOffset = 397;
  localparam int unsigned IdxW         = 10;
  localparam logic [31:0] TwistXor     = 32'h9908b0df;
  localparam logic [31:0] TemperB      = 32'h9d2c5680;
  localparam logic [31:0] TemperC      = 32'hefc60000;
  localparam logic [31:0] SeedMult     = 32'd1812433253;
  localparam logic [31:0] SeedReset    = 32'd5489;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage

@@ sv/mtrd_divider.sv @@
// Restoring divider, one quotient bit per cycle; keeps only the remainder.
module mtrd_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [30:0] rem_o
);
  logic [30:0] num_q, num_d, den_q, den_d;
  logic [30:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[30]};
    if (start_i) begin
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = 5'd30;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[29:0], 1'b0};
      // remainder stays below the divisor, so 31 bits always hold it
      if (trial >= {1'b0, den_q}) rem_d = 31'(trial - {1'b0, den_q});
      else rem_d = trial[30:0];
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

@@ sv/mersenne_twister_ranged_draw.sv @@
// Top level: MT19937 state memory, seeding sweep, twist sequencer, ranged reduction.
// Usage:
//  - seed_we_i/seed_i write the seed register; the state is refilled by a sweep over
//    all StateWords words (one word per cycle, one 32x32 multiply per word).
//    Reset runs the same sweep with seed 5489. bound_ready_o stays low meanwhile.
//  - bound_valid_i/bound_ready_o carry one request word (bound). Per request:
//    three memory reads over the one read port, twist with write-back,
//    then a 31-step remainder divider and its done cycle.
//  - out_valid_o rises when a draw, after RD0, RD1, RD2, TWIST and DIV (and HOLD
//    while the output register is taken), is loaded. A new word is accepted only
//    in IDLE, after the last draw loads; the divider loop and single read port pace it.
//  - The result (word_o, reduced_o, bad_bound_o) sits in an output register
//    under out_valid_o until out_ready_i. The next request may be taken while
//    it waits; a finished draw then waits in a hold state until the output
//    register is free, so only a stall longer than a draw holds the input.
//  - Zero bound: reduced_o is 0 and bad_bound_o is 1; the state still advances.
module mersenne_twister_ranged_draw #(
  parameter int unsigned STATE_WORDS   = mtrd_pkg::StateWords,
  parameter int unsigned MIDDLE_OFFSET = mtrd_pkg::MiddleOffset
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        bound_valid_i,
  output logic        bound_ready_o,
  input  logic [30:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_o,
  output logic [30:0] reduced_o,
  output logic        bad_bound_o
);
  localparam int unsigned IW = $clog2(STATE_WORDS);

  localparam logic [2:0] S_SEED  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD0   = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_RD2   = 3'd4;
  localparam logic [2:0] S_TWIST = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_HOLD  = 3'd7;

  logic [31:0] mem [STATE_WORDS];
  logic [31:0] rdata_q, here_q, next_q, prev_q, word_q, tw_q, seed_q;
  logic [2:0]  st_q, st_d;
  logic [IW-1:0] ptr_q, ptr_d, sidx_q, sidx_d, raddr;
  logic [IW-1:0] nptr, fptr;
  logic        we;
  logic [IW-1:0] waddr;
  logic [31:0] wdata, seedval, joined, fresh, mix, tempered;
  logic [30:0] bound_q;
  logic        ov_q, ov_d, start, ld;
  logic        div_done;
  logic [30:0] div_rem, red_q;
  logic        bad_q;

  assign nptr = (ptr_q == IW'(STATE_WORDS - 1)) ? '0 : ptr_q + IW'(1);
  assign fptr = (ptr_q >= IW'(STATE_WORDS - MIDDLE_OFFSET))
              ? ptr_q - IW'(STATE_WORDS - MIDDLE_OFFSET) : ptr_q + IW'(MIDDLE_OFFSET);

  assign mix      = prev_q ^ (prev_q >> 30);
  assign seedval  = mix * mtrd_pkg::SeedMult + 32'(sidx_q);
  assign joined   = {here_q[31], next_q[30:0]};
  assign fresh    = rdata_q ^ (joined >> 1) ^ (joined[0] ? mtrd_pkg::TwistXor : 32'd0);
  assign tempered = mtrd_pkg::temper(fresh);

  always_comb begin
    st_d   = st_q;
    ptr_d  = ptr_q;
    sidx_d = sidx_q;
    raddr  = ptr_q;
    we     = 1'b0;
    waddr  = sidx_q;
    wdata  = (sidx_q == '0) ? seed_q : seedval;
    ov_d   = ov_q;
    start  = 1'b0;
    ld     = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_SEED: begin
        // word 0 is the seed itself, prev_q holds the word just written
        we = 1'b1;
        if (sidx_q == IW'(STATE_WORDS - 1)) st_d = S_IDLE;
        else sidx_d = sidx_q + IW'(1);
      end
      S_IDLE: if (bound_valid_i && bound_ready_o) st_d = S_RD0;
      S_RD0: begin raddr = ptr_q; st_d = S_RD1; end
      S_RD1: begin raddr = nptr; st_d = S_RD2; end
      S_RD2: begin raddr = fptr; st_d = S_TWIST; end
      S_TWIST: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = fresh;
        ptr_d = nptr;
        start = 1'b1;
        st_d  = S_DIV;
      end
      S_DIV: if (div_done) begin
        if (!ov_q || out_ready_i) begin
          ld   = 1'b1;
          ov_d = 1'b1;
          st_d = S_IDLE;
        end else begin
          st_d = S_HOLD;
        end
      end
      // divider is idle here, its remainder stays put
      S_HOLD: if (!ov_q || out_ready_i) begin
        ld   = 1'b1;
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    if (seed_we_i) begin
      st_d   = S_SEED;
      sidx_d = '0;
      ptr_d  = '0;
    end
  end

  assign bound_ready_o = (st_q == S_IDLE) && !seed_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_SEED;
      sidx_q <= '0;
      ptr_q  <= '0;
      ov_q   <= 1'b0;
      prev_q <= '0;
      seed_q <= mtrd_pkg::SeedReset;
    end else begin
      st_q   <= st_d;
      sidx_q <= sidx_d;
      ptr_q  <= ptr_d;
      ov_q   <= ov_d;
      if (seed_we_i) seed_q <= seed_i;
      if (st_q == S_SEED) prev_q <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    if (st_q == S_RD1) here_q <= rdata_q;
    if (st_q == S_RD2) next_q <= rdata_q;
    if (st_q == S_TWIST) tw_q <= tempered;
    if (bound_valid_i && bound_ready_o) bound_q <= bound_i;
    if (ld) begin
      word_q <= tw_q;
      red_q  <= (bound_q == '0) ? '0 : div_rem;
      bad_q  <= (bound_q == '0);
    end
  end

  mtrd_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .dividend_i(tempered[31:1]),
    .divisor_i (bound_q),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  assign out_valid_o = ov_q;
  assign word_o      = word_q;
  assign reduced_o   = red_q;
  assign bad_bound_o = bad_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !bound_ready_o) else $error("accept while busy");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == S_DIV || seed_we_i || $past(seed_we_i)) || st_q == S_SEED)
    else $error("divider done outside division");
  a_out_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q == S_DIV || st_q == S_HOLD))
    else $error("result without division");
endmodule
